// ----- rtl/core/htt_pkg.sv -----
// htt_pkg: types, codes and character helpers for the html tag tokenizer
// no dependencies; used by every core module

package htt_pkg;

	// longest tag name, in bytes
	localparam int NAME_MAX   = 127;
	localparam int NAME_LEN_W = $clog2(NAME_MAX + 1);

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// token kinds
	localparam logic [2:0] TK_NAME  = 3'd0;
	localparam logic [2:0] TK_KEY   = 3'd1;
	localparam logic [2:0] TK_KEYE  = 3'd2;
	localparam logic [2:0] TK_VALUE = 3'd3;
	localparam logic [2:0] TK_DONE  = 3'd4;
	localparam logic [2:0] TK_ERROR = 3'd5;

	// tag types
	localparam logic [1:0] TT_OPEN  = 2'd0;
	localparam logic [1:0] TT_CLOSE = 2'd1;
	localparam logic [1:0] TT_EMPTY = 2'd2;

	// characters
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	// scanner phase, one-hot
	typedef enum logic [9:0] {
		PH_PRE      = 10'b00_0000_0001,
		PH_AFTER_LT = 10'b00_0000_0010,
		PH_AFTER_CL = 10'b00_0000_0100,
		PH_NAME     = 10'b00_0000_1000,
		PH_ATTR_WS  = 10'b00_0001_0000,
		PH_KEY      = 10'b00_0010_0000,
		PH_EQ       = 10'b00_0100_0000,
		PH_VALUE    = 10'b00_1000_0000,
		PH_EMPTY_GT = 10'b01_0000_0000,
		PH_FINISHED = 10'b10_0000_0000
	} phase_t;

	// one result token
	typedef struct packed {
		logic [2:0] token_kind;
		logic [7:0] token_byte;
		logic [1:0] tag_type;
		logic       last_of_run;
	} token_t;

	// the tokens caused by one input byte
	typedef struct packed {
		token_t tok0;
		token_t tok1;
		logic   two;
	} entry_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
	endfunction

	function automatic logic is_key_char(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h2D) || (c == 8'h3A);
	endfunction

endpackage

// ----- rtl/core/htt_in_if.sv -----
// htt_in_if: input byte channel of the html tag tokenizer
// depends on nothing beyond the valid/ready convention

interface htt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       buffer_end;

	modport source (output valid, output text_byte, output buffer_end, input ready);
	modport sink   (input valid, input text_byte, input buffer_end, output ready);
endinterface

// ----- rtl/core/htt_out_if.sv -----
// htt_out_if: output token channel of the html tag tokenizer
// depends on nothing beyond the valid/ready convention

interface htt_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] token_kind;
	logic [7:0] token_byte;
	logic [1:0] tag_type;
	logic       last_of_run;

	modport source (output valid, output token_kind, output token_byte,
		output tag_type, output last_of_run, input ready);
	modport sink   (input valid, input token_kind, input token_byte,
		input tag_type, input last_of_run, output ready);
endinterface

// ----- rtl/core/htt_front.sv -----
// htt_front: takes input bytes, runs the tag scanner and forms token entries
// depends on htt_pkg and htt_in_if

module htt_front (
	input  logic              clk,
	input  logic              arst_n,
	htt_in_if.sink            in_ch,
	input  logic              queue_full,
	output logic              push,
	output htt_pkg::entry_t   push_entry
);

	htt_pkg::phase_t               phase_q, phase_d;
	logic [htt_pkg::NAME_LEN_W-1:0] name_len_q, name_len_d;
	logic                          quote_single_q, quote_single_d;
	logic [1:0]                    kind_q, kind_d;

	logic             accept;
	logic [7:0]       c;
	logic             delim;
	logic             e_valid;
	htt_pkg::token_t  e_tok;
	logic             early_end;
	htt_pkg::token_t  err_tok;
	htt_pkg::entry_t  entry;

	assign in_ch.ready = !queue_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign c           = in_ch.text_byte;
	assign delim       = (c == htt_pkg::CH_GT) || (c == htt_pkg::CH_SLASH) || htt_pkg::is_space(c);

	// scanner next state and the token from this byte
	always_comb begin
		phase_d        = phase_q;
		name_len_d     = name_len_q;
		quote_single_d = quote_single_q;
		kind_d         = kind_q;
		e_valid        = 1'b0;
		e_tok          = '0;
		case (phase_q)
			htt_pkg::PH_PRE: begin
				if (c == htt_pkg::CH_LT) begin
					phase_d = htt_pkg::PH_AFTER_LT;
				end else if (!htt_pkg::is_space(c)) begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_ERROR;
					phase_d = htt_pkg::PH_FINISHED;
				end
			end
			htt_pkg::PH_AFTER_LT, htt_pkg::PH_AFTER_CL: begin
				if (htt_pkg::is_space(c)) begin
					phase_d = phase_q;
				end else if ((phase_q == htt_pkg::PH_AFTER_LT) && (c == htt_pkg::CH_SLASH)) begin
					kind_d  = htt_pkg::TT_CLOSE;
					phase_d = htt_pkg::PH_AFTER_CL;
				end else if (delim) begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_ERROR;
					phase_d = htt_pkg::PH_FINISHED;
				end else begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_NAME;
					e_tok.token_byte = htt_pkg::to_lower(c);
					name_len_d = htt_pkg::NAME_LEN_W'(1);
					phase_d    = htt_pkg::PH_NAME;
				end
			end
			htt_pkg::PH_NAME: begin
				if (htt_pkg::is_space(c)) begin
					phase_d = htt_pkg::PH_ATTR_WS;
				end else if (c == htt_pkg::CH_GT) begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_DONE;
					e_tok.tag_type = kind_q;
					phase_d = htt_pkg::PH_FINISHED;
				end else if (c == htt_pkg::CH_SLASH) begin
					kind_d  = htt_pkg::TT_EMPTY;
					phase_d = htt_pkg::PH_EMPTY_GT;
				end else if (name_len_q >= htt_pkg::NAME_LEN_W'(htt_pkg::NAME_MAX)) begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_ERROR;
					phase_d = htt_pkg::PH_FINISHED;
				end else begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_NAME;
					e_tok.token_byte = htt_pkg::to_lower(c);
					name_len_d = name_len_q + htt_pkg::NAME_LEN_W'(1);
				end
			end
			htt_pkg::PH_ATTR_WS: begin
				if (htt_pkg::is_space(c)) begin
					phase_d = phase_q;
				end else if (c == htt_pkg::CH_GT) begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_DONE;
					e_tok.tag_type = kind_q;
					phase_d = htt_pkg::PH_FINISHED;
				end else if (c == htt_pkg::CH_SLASH) begin
					kind_d  = htt_pkg::TT_EMPTY;
					phase_d = htt_pkg::PH_EMPTY_GT;
				end else if (htt_pkg::is_key_char(c)) begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_KEY;
					e_tok.token_byte = htt_pkg::to_lower(c);
					phase_d = htt_pkg::PH_KEY;
				end else begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_ERROR;
					phase_d = htt_pkg::PH_FINISHED;
				end
			end
			htt_pkg::PH_KEY: begin
				if (htt_pkg::is_key_char(c)) begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_KEY;
					e_tok.token_byte = htt_pkg::to_lower(c);
				end else if (c == htt_pkg::CH_EQ) begin
					phase_d = htt_pkg::PH_EQ;
				end else begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_ERROR;
					phase_d = htt_pkg::PH_FINISHED;
				end
			end
			htt_pkg::PH_EQ: begin
				if ((c == htt_pkg::CH_DQUOTE) || (c == htt_pkg::CH_SQUOTE)) begin
					quote_single_d = (c == htt_pkg::CH_SQUOTE);
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_KEYE;
					phase_d = htt_pkg::PH_VALUE;
				end else begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_ERROR;
					phase_d = htt_pkg::PH_FINISHED;
				end
			end
			htt_pkg::PH_VALUE: begin
				if (c == (quote_single_q ? htt_pkg::CH_SQUOTE : htt_pkg::CH_DQUOTE)) begin
					phase_d = htt_pkg::PH_ATTR_WS;
				end else begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_VALUE;
					e_tok.token_byte = c;
				end
			end
			htt_pkg::PH_EMPTY_GT: begin
				if (htt_pkg::is_space(c)) begin
					phase_d = phase_q;
				end else if (c == htt_pkg::CH_GT) begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_DONE;
					e_tok.tag_type = kind_q;
					phase_d = htt_pkg::PH_FINISHED;
				end else begin
					e_valid = 1'b1; e_tok.token_kind = htt_pkg::TK_ERROR;
					phase_d = htt_pkg::PH_FINISHED;
				end
			end
			default: begin
				phase_d = htt_pkg::PH_FINISHED;
			end
		endcase

		// end of buffer: unfinished tag is an error, then back to reset values
		early_end = in_ch.buffer_end && (phase_d != htt_pkg::PH_FINISHED);
		if (in_ch.buffer_end) begin
			phase_d        = htt_pkg::PH_PRE;
			name_len_d     = '0;
			quote_single_d = 1'b0;
			kind_d         = htt_pkg::TT_OPEN;
		end
	end

	// pack the tokens of this byte, marking the final one
	always_comb begin
		err_tok             = '0;
		err_tok.token_kind  = htt_pkg::TK_ERROR;
		err_tok.last_of_run = 1'b1;
		entry               = '0;
		if (e_valid) begin
			entry.tok0             = e_tok;
			entry.tok0.last_of_run = !early_end;
			entry.tok1             = err_tok;
			entry.two              = early_end;
		end else begin
			entry.tok0 = err_tok;
		end
	end

	assign push       = accept && (e_valid || early_end);
	assign push_entry = entry;

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= htt_pkg::PH_PRE;
			name_len_q     <= '0;
			quote_single_q <= 1'b0;
			kind_q         <= htt_pkg::TT_OPEN;
		end else if (accept) begin
			phase_q        <= phase_d;
			name_len_q     <= name_len_d;
			quote_single_q <= quote_single_d;
			kind_q         <= kind_d;
		end
	end

endmodule

// ----- rtl/core/htt_queue.sv -----
// htt_queue: short queue of token entries between front and back
// depends on htt_pkg

module htt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  htt_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output htt_pkg::entry_t head
);

	htt_pkg::entry_t                mem_q [htt_pkg::QUEUE_DEPTH];
	logic [htt_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [htt_pkg::QUEUE_CNT_W-1:0] count_q;
	logic                           do_push, do_pop;

	assign full      = (count_q == htt_pkg::QUEUE_CNT_W'(htt_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + htt_pkg::QUEUE_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + htt_pkg::QUEUE_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + htt_pkg::QUEUE_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - htt_pkg::QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/htt_back.sv -----
// htt_back: drains queued entries and sends their tokens one request at a time
// depends on htt_pkg and htt_out_if

module htt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            not_empty,
	input  htt_pkg::entry_t head,
	output logic            pop,
	htt_out_if.source       out_ch
);

	logic            out_valid_q;
	htt_pkg::token_t out_tok_q;
	logic            pend_q;
	htt_pkg::token_t pend_tok_q;
	logic            load;

	// output register free this cycle
	assign load = !out_valid_q || out_ch.ready;
	assign pop  = load && !pend_q && not_empty;

	assign out_ch.valid       = out_valid_q;
	assign out_ch.token_kind  = out_tok_q.token_kind;
	assign out_ch.token_byte  = out_tok_q.token_byte;
	assign out_ch.tag_type    = out_tok_q.tag_type;
	assign out_ch.last_of_run = out_tok_q.last_of_run;

	// control: output valid and second token pending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				out_valid_q <= not_empty;
				pend_q      <= not_empty && head.two;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_tok_q <= pend_tok_q;
			end else if (not_empty) begin
				out_tok_q  <= head.tok0;
				pend_tok_q <= head.tok1;
			end
		end
	end

endmodule

// ----- rtl/core/html_tag_tokenizer.sv -----
// html_tag_tokenizer: top level of the single tag tokenizer
// depends on htt_pkg, htt_in_if, htt_out_if, htt_front, htt_queue, htt_back
//
//   channel   dir   payload                                          unit
//   in_ch     in    text_byte[7:0], buffer_end                       one byte
//   out_ch    out   token_kind[2:0], token_byte[7:0], tag_type[1:0], one token
//                   last_of_run
//
// one byte is taken per cycle while the queue is not full; a byte that gives two
// tokens sends them in turn, one after the other, from the output register.
// the scanner state machine in the front decides each byte in the cycle it is taken.
// a four-entry queue lets input requests continue while the output stalls.
// reset empties the queue and returns the scanner to waiting for the bracket.

module html_tag_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	htt_in_if.sink     in_ch,
	htt_out_if.source  out_ch
);

	logic            push;
	htt_pkg::entry_t push_entry;
	logic            queue_full;
	logic            pop;
	logic            not_empty;
	htt_pkg::entry_t head;

	// scanner
	htt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue
	htt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	// token sender
	htt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule
